// ----- hdl/scara_kinematics_step_rate_top_assert.svh -----
// Assertion macros for the SCARA step-rate block checker.
// Needs clk and arst_n in scope where a macro is used.
`ifndef SCARA_KINEMATICS_STEP_RATE_TOP_ASSERT_SVH
`define SCARA_KINEMATICS_STEP_RATE_TOP_ASSERT_SVH

// same-cycle implication
`define SKSR_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sksr assertion failed");

// next-cycle implication
`define SKSR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sksr assertion failed");

`endif

// ----- hdl/sksr_pkg.sv -----
// Shared types, constants and tables for the SCARA step-rate block.
// No dependencies.
`timescale 1ns / 1ps

package sksr_pkg;

	localparam int NUM_AXES     = 3;
	localparam int ZSPM_DEFAULT = 80;
	localparam int CORDIC_STEPS = 28;
	localparam int DIV_STEPS    = 30;
	localparam int SQRT_STEPS   = 31;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 32;

	localparam logic signed [31:0] PI_Q28 = 32'sd843314857;

	localparam logic [23:0] RST_SCALE = 24'd65536;
	localparam logic [30:0] RST_LINK  = 31'd9830400;
	localparam logic [31:0] RST_SPR   = 32'd65536000;

	localparam logic [CFG_IDX_W-1:0] REG_SCALE_X  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_UPPER    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_FORE     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SPR_SH   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPR_EL   = 3'd7;

	typedef enum logic [4:0] {
		OP_NONE, OP_LOAD, OP_MX, OP_MY, OP_PY, OP_SQX, OP_SQY, OP_L1, OP_L2,
		OP_DEN, OP_NUM, OP_DIVINIT, OP_DIV, OP_CSET, OP_CSQ, OP_SQINIT, OP_SQRT,
		OP_K1, OP_K2, OP_K2L, OP_AGO, OP_AWAIT, OP_ST, OP_SE, OP_SZ, OP_ZL, OP_EMIT
	} op_t;

	typedef enum logic [4:0] {
		S_IDLE, S_MX, S_MY, S_PY, S_SQX, S_SQY, S_L1, S_L2, S_DEN, S_NUM,
		S_DIVINIT, S_DIV, S_CSET, S_CSQ, S_SQINIT, S_SQRT, S_K1, S_K2, S_K2L,
		S_A1, S_A1W, S_A2, S_A2W, S_A3, S_A3W, S_ST, S_SE, S_SZ, S_ZL, S_EMIT
	} st_t;

	typedef enum logic [1:0] {
		ASEL_ELBOW, ASEL_TARGET, ASEL_PSI
	} asel_t;

	typedef enum logic [1:0] {
		C_IDLE, C_NORM, C_ITER, C_FIX
	} cst_t;

	typedef struct packed {
		op_t        op;
		logic [4:0] cnt;
		asel_t      sel;
		logic       cordic_go;
	} cmd_t;

	typedef struct packed {
		logic cordic_done;
	} sts_t;

	// arctangent of 2^-i, Q.28 radians
	function automatic logic [27:0] atan_entry(input logic [4:0] i);
		logic [27:0] r;
		unique case (i)
			5'd0:  r = 28'd210828714;
			5'd1:  r = 28'd124459457;
			5'd2:  r = 28'd65760959;
			5'd3:  r = 28'd33381290;
			5'd4:  r = 28'd16755422;
			5'd5:  r = 28'd8385879;
			5'd6:  r = 28'd4193963;
			5'd7:  r = 28'd2097109;
			5'd8:  r = 28'd1048571;
			5'd9:  r = 28'd524287;
			5'd10: r = 28'd262144;
			5'd11: r = 28'd131072;
			5'd12: r = 28'd65536;
			5'd13: r = 28'd32768;
			5'd14: r = 28'd16384;
			5'd15: r = 28'd8192;
			5'd16: r = 28'd4096;
			5'd17: r = 28'd2048;
			5'd18: r = 28'd1024;
			5'd19: r = 28'd512;
			5'd20: r = 28'd256;
			5'd21: r = 28'd128;
			5'd22: r = 28'd64;
			5'd23: r = 28'd32;
			5'd24: r = 28'd16;
			5'd25: r = 28'd8;
			5'd26: r = 28'd4;
			5'd27: r = 28'd2;
			default: r = 28'd0;
		endcase
		return r;
	endfunction

endpackage

// ----- hdl/sksr_cordic.sv -----
// Iterative atan2 unit: normalizing shifts, 28 vectoring rotations, quadrant fix.
// Depends on sksr_pkg.
`timescale 1ns / 1ps

module sksr_cordic import sksr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               go,
	input  logic signed [33:0] y_in,
	input  logic signed [33:0] x_in,
	output logic               done,
	output logic signed [31:0] angle
);

	cst_t               cst_q, cst_d;
	logic [33:0]        ax_q, ay_q, m;
	logic signed [33:0] cx_q, cy_q, dx, dy;
	logic signed [31:0] z_q, a, tab;
	logic [4:0]         it_q;
	logic               xneg_q, yneg_q;

	assign m   = (ax_q > ay_q) ? ax_q : ay_q;
	assign dx  = cy_q >>> it_q;
	assign dy  = cx_q >>> it_q;
	assign tab = $signed({4'b0, atan_entry(it_q)});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cst_q <= C_IDLE;
		else cst_q <= cst_d;
	end

	always_comb begin
		cst_d = cst_q;
		unique case (cst_q)
			C_IDLE: if (go) cst_d = C_NORM;
			C_NORM: begin
				if (m == 34'd0) cst_d = C_FIX;
				else if (m < 34'h4000_0000 && m >= 34'h2000_0000) cst_d = C_ITER;
			end
			C_ITER: if (it_q == 5'(CORDIC_STEPS - 1)) cst_d = C_FIX;
			C_FIX:  cst_d = C_IDLE;
			default: cst_d = C_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (cst_q)
			C_IDLE: begin
				if (go) begin
					ax_q   <= x_in[33] ? 34'(-x_in) : 34'(x_in);
					ay_q   <= y_in[33] ? 34'(-y_in) : 34'(y_in);
					xneg_q <= x_in[33];
					yneg_q <= y_in[33];
					z_q    <= 32'sd0;
				end
			end
			C_NORM: begin
				if (m >= 34'h4000_0000) begin
					ax_q <= ax_q >> 1;
					ay_q <= ay_q >> 1;
				end else if (m < 34'h2000_0000) begin
					ax_q <= ax_q << 1;
					ay_q <= ay_q << 1;
				end else begin
					cx_q <= $signed(ax_q);
					cy_q <= $signed(ay_q);
					it_q <= 5'd0;
				end
			end
			C_ITER: begin
				if (cy_q > 0) begin
					cx_q <= cx_q + dx;
					cy_q <= cy_q - dy;
					z_q  <= z_q + tab;
				end else if (cy_q < 0) begin
					cx_q <= cx_q - dx;
					cy_q <= cy_q + dy;
					z_q  <= z_q - tab;
				end
				it_q <= it_q + 5'd1;
			end
			default: ;
		endcase
	end

	always_comb begin
		a = z_q;
		if (xneg_q) a = PI_Q28 - a;
		if (yneg_q) a = -a;
	end

	assign done  = (cst_q == C_FIX);
	assign angle = a;

endmodule

// ----- hdl/sksr_dpath.sv -----
// Datapath: configuration registers, shared multiplier, divider and square-root
// steps, atan2 unit, step conversion and result registers. Depends on sksr_pkg, sksr_cordic.
`timescale 1ns / 1ps

module sksr_dpath import sksr_pkg::*; #(
	parameter int Z_STEPS_PER_MM = ZSPM_DEFAULT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmd_t                  cmd,
	output sts_t                  sts,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  func,
	input  logic signed [31:0]    target_x,
	input  logic signed [31:0]    target_y,
	input  logic signed [31:0]    target_z,
	output logic signed [31:0]    shoulder_steps,
	output logic signed [31:0]    elbow_steps,
	output logic signed [31:0]    z_steps,
	output logic [15:0]           rate_shoulder,
	output logic [15:0]           rate_elbow,
	output logic [15:0]           rate_z,
	output logic                  out_of_reach
);

	localparam logic signed [50:0] S32_MAX = 51'sd2147483647;
	localparam logic signed [50:0] S32_MIN = -51'sd2147483648;

	logic [23:0]        scale_x_q, scale_y_q;
	logic signed [31:0] offx_q, offy_q;
	logic [30:0]        upper_q, fore_q;
	logic [31:0]        spr_sh_q, spr_el_q;

	logic               zero_q, neg_q, clamp_q, den0_q;
	logic signed [31:0] tx_q, ty_q, tz_q, px_q, py_q, c_q, a1_q, psi_q;
	logic signed [32:0] theta_q;
	logic signed [65:0] prod_q;
	logic signed [32:0] ma, mb;
	logic [64:0]        r2_q, lsum_q, den_q, nmag_q;
	logic [65:0]        rem_q, rsh;
	logic [30:0]        quo_q, cmag_q, k2_q;
	logic [60:0]        v_q;
	logic [61:0]        res_q, bitv, trial;
	logic signed [33:0] k1_q, cy_in, cx_in;
	logic signed [35:0] k1w;
	logic signed [50:0] pxw, pyw;
	logic signed [31:0] sh_q, el_q, zs_q, angle;
	logic signed [31:0] prev_pos_q [NUM_AXES];
	logic signed [31:0] pos [NUM_AXES];
	logic [15:0]        rate [NUM_AXES];
	logic               cordic_done;

	function automatic logic [31:0] mag32(input logic signed [31:0] v);
		return v[31] ? 32'(-v) : 32'(v);
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [50:0] v);
		logic signed [31:0] r;
		if (v > S32_MAX) r = 32'sh7FFF_FFFF;
		else if (v < S32_MIN) r = 32'sh8000_0000;
		else r = v[31:0];
		return r;
	endfunction

	function automatic logic signed [31:0] to_steps(input logic [19:0] m, input logic neg);
		logic [31:0] e;
		e = {12'b0, m};
		return neg ? $signed(-e) : $signed(e);
	endfunction

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_x_q <= RST_SCALE;
			scale_y_q <= RST_SCALE;
			offx_q    <= 32'sd0;
			offy_q    <= 32'sd0;
			upper_q   <= RST_LINK;
			fore_q    <= RST_LINK;
			spr_sh_q  <= RST_SPR;
			spr_el_q  <= RST_SPR;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SCALE_X:  scale_x_q <= cfg_data[23:0];
				REG_SCALE_Y:  scale_y_q <= cfg_data[23:0];
				REG_OFFSET_X: offx_q    <= $signed(cfg_data);
				REG_OFFSET_Y: offy_q    <= $signed(cfg_data);
				REG_UPPER:    upper_q   <= cfg_data[30:0];
				REG_FORE:     fore_q    <= cfg_data[30:0];
				REG_SPR_SH:   spr_sh_q  <= cfg_data;
				REG_SPR_EL:   spr_el_q  <= cfg_data;
			endcase
		end
	end

	// shared multiplier operand select
	always_comb begin
		ma = 33'sd0;
		mb = 33'sd0;
		unique case (cmd.op)
			OP_MX: begin ma = {tx_q[31], tx_q}; mb = $signed({9'b0, scale_x_q}); end
			OP_MY: begin ma = {ty_q[31], ty_q}; mb = $signed({9'b0, scale_y_q}); end
			OP_PY: begin ma = $signed({1'b0, mag32(px_q)}); mb = ma; end
			OP_SQX: begin ma = $signed({1'b0, mag32(py_q)}); mb = ma; end
			OP_SQY: begin ma = $signed({2'b0, upper_q}); mb = ma; end
			OP_L1: begin ma = $signed({2'b0, fore_q}); mb = ma; end
			OP_L2: begin ma = $signed({2'b0, upper_q}); mb = $signed({2'b0, fore_q}); end
			OP_CSQ: begin ma = $signed({2'b0, cmag_q}); mb = ma; end
			OP_K1: begin ma = $signed({2'b0, fore_q}); mb = {c_q[31], c_q}; end
			OP_K2: begin ma = $signed({2'b0, fore_q}); mb = $signed({2'b0, res_q[30:0]}); end
			OP_ST: begin
				ma = $signed({1'b0, theta_q[32] ? 32'(-theta_q) : theta_q[31:0]});
				mb = $signed({1'b0, spr_sh_q});
			end
			OP_SE: begin ma = $signed({1'b0, mag32(psi_q)}); mb = $signed({1'b0, spr_el_q}); end
			OP_SZ: begin ma = $signed({1'b0, mag32(tz_q)}); mb = 33'(Z_STEPS_PER_MM); end
			default: ;
		endcase
	end

	assign pxw   = $signed({prod_q[65], prod_q[65:16]}) - 51'(offx_q);
	assign pyw   = $signed({prod_q[65], prod_q[65:16]}) - 51'(offy_q);
	assign rsh   = {rem_q[64:0], 1'b0};
	assign bitv  = 62'd1 << {cmd.cnt, 1'b0};
	assign trial = res_q + bitv;
	assign k1w   = $signed({5'b0, upper_q}) + $signed(prod_q[65:30]);

	always_comb begin
		unique case (cmd.sel)
			ASEL_ELBOW: begin cy_in = k1_q; cx_in = $signed({3'b0, k2_q}); end
			ASEL_TARGET: begin cy_in = 34'(px_q); cx_in = 34'(py_q); end
			ASEL_PSI: begin cy_in = $signed({3'b0, res_q[30:0]}); cx_in = 34'(c_q); end
			default: begin cy_in = 34'sd0; cx_in = 34'sd0; end
		endcase
	end

	sksr_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (cmd.cordic_go),
		.y_in   (cy_in),
		.x_in   (cx_in),
		.done   (cordic_done),
		.angle  (angle)
	);

	assign sts.cordic_done = cordic_done;

	assign pos[0] = sh_q;
	assign pos[1] = el_q;
	assign pos[2] = zs_q;

	always_comb begin
		logic signed [32:0] d;
		logic [32:0]        m;
		for (int i = 0; i < NUM_AXES; i++) begin
			d = {pos[i][31], pos[i]} - {prev_pos_q[i][31], prev_pos_q[i]};
			m = d[32] ? 33'(-d) : 33'(d);
			rate[i] = {(!d[32] && d != 33'sd0), (m > 33'd32767) ? 15'h7FFF : m[14:0]};
			if (zero_q) rate[i] = 16'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_AXES; i++) prev_pos_q[i] <= 32'sd0;
		end else if (cmd.op == OP_EMIT) begin
			for (int i = 0; i < NUM_AXES; i++) prev_pos_q[i] <= pos[i];
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= ma * mb;
		unique case (cmd.op)
			OP_LOAD: begin
				zero_q <= func;
				tx_q   <= func ? 32'sd0 : target_x;
				ty_q   <= func ? 32'sd0 : target_y;
				tz_q   <= func ? 32'sd0 : target_z;
			end
			OP_MY:  px_q <= sat32(pxw);
			OP_PY:  py_q <= sat32(pyw);
			OP_SQX: r2_q <= {1'b0, prod_q[63:0]};
			OP_SQY: r2_q <= r2_q + {1'b0, prod_q[63:0]};
			OP_L1:  lsum_q <= {1'b0, prod_q[63:0]};
			OP_L2:  lsum_q <= lsum_q + {1'b0, prod_q[63:0]};
			OP_DEN: den_q <= {prod_q[63:0], 1'b0};
			OP_NUM: begin
				neg_q  <= r2_q < lsum_q;
				nmag_q <= (r2_q < lsum_q) ? lsum_q - r2_q : r2_q - lsum_q;
			end
			OP_DIVINIT: begin
				clamp_q <= nmag_q > den_q;
				den0_q  <= den_q == 65'd0;
				if (nmag_q >= den_q) begin
					quo_q <= 31'd1;
					rem_q <= {1'b0, nmag_q - den_q};
				end else begin
					quo_q <= 31'd0;
					rem_q <= {1'b0, nmag_q};
				end
			end
			OP_DIV: begin
				if (rsh >= {1'b0, den_q}) begin
					rem_q <= rsh - {1'b0, den_q};
					quo_q <= {quo_q[29:0], 1'b1};
				end else begin
					rem_q <= rsh;
					quo_q <= {quo_q[29:0], 1'b0};
				end
			end
			OP_CSET: cmag_q <= clamp_q ? 31'h4000_0000 : (den0_q ? 31'd0 : quo_q);
			OP_CSQ: c_q <= neg_q ? $signed(-{1'b0, cmag_q}) : $signed({1'b0, cmag_q});
			OP_SQINIT: begin
				v_q   <= {1'b1, 60'b0} - prod_q[60:0];
				res_q <= 62'd0;
			end
			OP_SQRT: begin
				if ({1'b0, v_q} >= trial) begin
					v_q   <= 61'({1'b0, v_q} - trial);
					res_q <= (res_q >> 1) + bitv;
				end else begin
					res_q <= res_q >> 1;
				end
			end
			OP_K2:  k1_q <= k1w[33:0];
			OP_K2L: k2_q <= prod_q[60:30];
			OP_AWAIT: begin
				if (cordic_done) begin
					unique case (cmd.sel)
						ASEL_ELBOW:  a1_q <= angle;
						ASEL_TARGET: theta_q <= {a1_q[31], a1_q} - {angle[31], angle};
						ASEL_PSI:    psi_q <= angle;
						default: ;
					endcase
				end
			end
			OP_SE: sh_q <= to_steps(prod_q[63:44], theta_q[32]);
			OP_SZ: el_q <= to_steps(prod_q[63:44], psi_q[31]);
			OP_ZL: zs_q <= tz_q[31] ? $signed(-prod_q[47:16]) : $signed(prod_q[47:16]);
			OP_EMIT: begin
				shoulder_steps <= sh_q;
				elbow_steps    <= el_q;
				z_steps        <= zs_q;
				rate_shoulder  <= rate[0];
				rate_elbow     <= rate[1];
				rate_z         <= rate[2];
				out_of_reach   <= clamp_q;
			end
			default: ;
		endcase
	end

endmodule

// ----- hdl/sksr_ctrl.sv -----
// Controller: sequences the datapath one transaction at a time and owns the handshakes.
// Depends on sksr_pkg.
`timescale 1ns / 1ps

module sksr_ctrl import sksr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	st_t        state_q, state_d;
	logic [4:0] cnt_q, cnt_d;
	logic       out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= 5'd0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			out_valid_q <= (cmd.op == OP_EMIT) | (out_valid_q & ~out_ready);
		end
	end

	always_comb begin
		state_d       = state_q;
		cnt_d         = cnt_q;
		cmd.op        = OP_NONE;
		cmd.cnt       = cnt_q;
		cmd.sel       = ASEL_TARGET;
		cmd.cordic_go = 1'b0;
		unique case (state_q)
			S_IDLE: if (in_valid) begin cmd.op = OP_LOAD; state_d = S_MX; end
			S_MX:  begin cmd.op = OP_MX;  state_d = S_MY;  end
			S_MY:  begin cmd.op = OP_MY;  state_d = S_PY;  end
			S_PY:  begin cmd.op = OP_PY;  state_d = S_SQX; end
			S_SQX: begin cmd.op = OP_SQX; state_d = S_SQY; end
			S_SQY: begin cmd.op = OP_SQY; state_d = S_L1;  end
			S_L1:  begin cmd.op = OP_L1;  state_d = S_L2;  end
			S_L2:  begin cmd.op = OP_L2;  state_d = S_DEN; end
			S_DEN: begin cmd.op = OP_DEN; state_d = S_NUM; end
			S_NUM: begin cmd.op = OP_NUM; state_d = S_DIVINIT; end
			S_DIVINIT: begin
				cmd.op  = OP_DIVINIT;
				cnt_d   = 5'(DIV_STEPS - 1);
				state_d = S_DIV;
			end
			S_DIV: begin
				cmd.op = OP_DIV;
				if (cnt_q == 5'd0) state_d = S_CSET;
				else cnt_d = cnt_q - 5'd1;
			end
			S_CSET: begin cmd.op = OP_CSET; state_d = S_CSQ; end
			S_CSQ:  begin cmd.op = OP_CSQ;  state_d = S_SQINIT; end
			S_SQINIT: begin
				cmd.op  = OP_SQINIT;
				cnt_d   = 5'(SQRT_STEPS - 1);
				state_d = S_SQRT;
			end
			S_SQRT: begin
				cmd.op = OP_SQRT;
				if (cnt_q == 5'd0) state_d = S_K1;
				else cnt_d = cnt_q - 5'd1;
			end
			S_K1:  begin cmd.op = OP_K1;  state_d = S_K2;  end
			S_K2:  begin cmd.op = OP_K2;  state_d = S_K2L; end
			S_K2L: begin cmd.op = OP_K2L; state_d = S_A1;  end
			S_A1: begin
				cmd.op = OP_AGO; cmd.sel = ASEL_ELBOW; cmd.cordic_go = 1'b1; state_d = S_A1W;
			end
			S_A1W: begin
				cmd.op = OP_AWAIT; cmd.sel = ASEL_ELBOW;
				if (sts.cordic_done) state_d = S_A2;
			end
			S_A2: begin
				cmd.op = OP_AGO; cmd.sel = ASEL_TARGET; cmd.cordic_go = 1'b1; state_d = S_A2W;
			end
			S_A2W: begin
				cmd.op = OP_AWAIT; cmd.sel = ASEL_TARGET;
				if (sts.cordic_done) state_d = S_A3;
			end
			S_A3: begin
				cmd.op = OP_AGO; cmd.sel = ASEL_PSI; cmd.cordic_go = 1'b1; state_d = S_A3W;
			end
			S_A3W: begin
				cmd.op = OP_AWAIT; cmd.sel = ASEL_PSI;
				if (sts.cordic_done) state_d = S_ST;
			end
			S_ST: begin cmd.op = OP_ST; state_d = S_SE; end
			S_SE: begin cmd.op = OP_SE; state_d = S_SZ; end
			S_SZ: begin cmd.op = OP_SZ; state_d = S_ZL; end
			S_ZL: begin cmd.op = OP_ZL; state_d = S_EMIT; end
			S_EMIT: begin
				if (!out_valid_q || out_ready) begin
					cmd.op  = OP_EMIT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

endmodule

// ----- hdl/scara_kinematics_step_rate_top.sv -----
// SCARA inverse kinematics with step-rate output: top level.
// Processes one transaction at a time: a new one is accepted only after the last
// is emitted. The steps are load, products, a 30-step restoring divider for the
// elbow cosine, a 31-step square root and the step conversions, all through one
// 33x33 multiplier, with three passes through the single shared atan2 unit
// between the square root and the step conversions. Each pass makes up to 29
// normalizing shifts before its rotations, and none when both operands are zero.
// A finished result sits in the output register while the next transaction is
// accepted; config writes are taken any time the block is idle. No clearing
// pass after reset. Depends on sksr_pkg, sksr_ctrl, sksr_dpath.
`timescale 1ns / 1ps

module scara_kinematics_step_rate_top import sksr_pkg::*; #(
	parameter int Z_STEPS_PER_MM = ZSPM_DEFAULT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  func,
	input  logic signed [31:0]    target_x,
	input  logic signed [31:0]    target_y,
	input  logic signed [31:0]    target_z,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic signed [31:0]    shoulder_steps,
	output logic signed [31:0]    elbow_steps,
	output logic signed [31:0]    z_steps,
	output logic [15:0]           rate_shoulder,
	output logic [15:0]           rate_elbow,
	output logic [15:0]           rate_z,
	output logic                  out_of_reach
);

	cmd_t cmd;
	sts_t sts;

	sksr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	sksr_dpath #(
		.Z_STEPS_PER_MM (Z_STEPS_PER_MM)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.func           (func),
		.target_x       (target_x),
		.target_y       (target_y),
		.target_z       (target_z),
		.shoulder_steps (shoulder_steps),
		.elbow_steps    (elbow_steps),
		.z_steps        (z_steps),
		.rate_shoulder  (rate_shoulder),
		.rate_elbow     (rate_elbow),
		.rate_z         (rate_z),
		.out_of_reach   (out_of_reach)
	);

endmodule

// ----- hdl/sksr_checker.sv -----
// Port-level checker for the SCARA step-rate block, bound to the top level.
// Depends on scara_kinematics_step_rate_top_assert.svh.
`timescale 1ns / 1ps
`include "scara_kinematics_step_rate_top_assert.svh"

module sksr_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [31:0] shoulder_steps,
	input logic [15:0]        rate_z
);

	`SKSR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
	`SKSR_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(shoulder_steps))
	`SKSR_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
	`SKSR_ASSERT_IMP(a_rate_dir, out_valid, !(rate_z[15] && (rate_z[14:0] == 15'd0)))

endmodule

bind scara_kinematics_step_rate_top sksr_checker u_sksr_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_ready       (in_ready),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.shoulder_steps (shoulder_steps),
	.rate_z         (rate_z)
);
